>>> sv/rfs_pkg.sv
`default_nettype none
package rfs_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int CUTOFF_W       = 17;
  localparam int SIZE_W         = 13;
  localparam int GREY_W         = 8;
  localparam int DIST_W         = 17;   // normalised distance, q1.16
  localparam int ROOT_USE_W     = 30;   // root bits that matter when not far
  localparam int RAMP_NUM_W     = 24;   // 255 * (1 - d) in q.16
  localparam int FRAC_SHIFT     = 32;   // s << 32 before the square root

  localparam logic [CUTOFF_W-1:0] CUTOFF_RESET = 17'd32768;
  localparam logic [SIZE_W-1:0]   SIZE_RESET   = 13'd256;
  localparam logic [DIST_W-1:0]   ONE_Q16      = 17'd65536;
  localparam logic [DIST_W-1:0]   D_MAX        = 17'd131071;
  localparam logic [GREY_W-1:0]   GREY_FULL    = 8'd255;
  localparam logic [GREY_W-1:0]   GREY_ZERO    = 8'd0;

  // register indexes
  localparam logic REG_CUTOFF = 1'b0;
  localparam logic REG_SIZE   = 1'b1;

  typedef enum logic [2:0] {
    MODE_FULL = 3'b001,
    MODE_ZERO = 3'b010,
    MODE_RAMP = 3'b100
  } mode_t;

endpackage
`default_nettype wire

>>> sv/radial_falloff_stencil.sv
`default_nettype none
// channel   | signals                         | direction
// ----------+---------------------------------+----------
// request   | in_valid, in_stall, row, column | in
// result    | out_valid, out_stall, grey      | out
// config    | write_enable/index/data         | in
//
// one request enters per cycle unless out_stall holds the pipe; RW is half the
// radicand width (30 at 12-bit coordinates); the path is offset, bit-per-stage
// root, bit-per-stage root / n divider, ramp register, bit-per-stage ramp divider,
// and output register; synchronous reset empties the pipe, loads cutoff 0.5, size 256
// the whole pipe holds while a result waits under out_stall; in_stall follows
module radial_falloff_stencil import rfs_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  write_enable,
  input  wire logic                  write_index,
  input  wire logic [CUTOFF_W-1:0]   write_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [COORD_BITS-1:0] row,
  input  wire logic [COORD_BITS-1:0] column,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [GREY_W-1:0]          grey
);

  // widths that follow from the coordinate size
  localparam int DW     = ((COORD_BITS + 1) > SIZE_W) ? (COORD_BITS + 1) : SIZE_W;
  localparam int SW     = 2 * DW + 1;
  localparam int XW_RAW = SW + FRAC_SHIFT;
  localparam int XW     = XW_RAW + (XW_RAW % 2);
  localparam int RW     = XW / 2;

  logic [CUTOFF_W-1:0] cutoff;
  logic [SIZE_W-1:0]   texture_size;
  logic [SIZE_W-1:0]   n;
  logic [DIST_W-1:0]   ramp_den;
  logic                en;

  logic                off_valid;
  logic [SW-1:0]       off_s;
  logic                off_far;

  logic                sq_valid;
  logic [RW-1:0]       sq_root;
  logic                sq_far;

  logic                dv1_valid;
  logic [DIST_W-1:0]   dv1_q;
  logic                dv1_far;

  logic [DIST_W-1:0]   dist_q;
  logic [DIST_W-1:0]   one_minus;
  logic [RAMP_NUM_W:0] ramp_wide;
  logic                ramp_valid;
  logic [RAMP_NUM_W-1:0] ramp_num;
  mode_t               ramp_mode;
  mode_t               mode_next;

  logic                dv2_valid;
  logic [GREY_W-1:0]   dv2_q;
  logic [2:0]          dv2_sb;
  mode_t               dv2_mode;

  // config registers; the user must write them only while the pipe is empty (not enforced)
  always_ff @(posedge clk) begin
    if (rst) begin
      cutoff       <= CUTOFF_RESET;
      texture_size <= SIZE_RESET;
    end else if (write_enable) begin
      case (write_index)
        REG_CUTOFF: cutoff       <= write_data;
        REG_SIZE:   texture_size <= write_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // zero size behaves as one
  assign n        = (texture_size == '0) ? SIZE_W'(1) : texture_size;
  assign ramp_den = ONE_Q16 - cutoff;

  // global advance: everything moves unless a finished result is held
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  rfs_offset #(
    .CW (COORD_BITS),
    .DW (DW),
    .SW (SW)
  ) u_offset (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .row       (row),
    .column    (column),
    .n         (n),
    .out_valid (off_valid),
    .s         (off_s),
    .far       (off_far)
  );

  // integer root of s * 2^32
  rfs_sqrt #(
    .XW   (XW),
    .SB_W (1),
    .RW   (RW)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (off_valid),
    .x_in      (XW'({off_s, {FRAC_SHIFT{1'b0}}})),
    .sb_in     (off_far),
    .out_valid (sq_valid),
    .root_out  (sq_root),
    .sb_out    (sq_far)
  );

  // root / n; below the far limit the root is under 2^30 and d under 2^17
  rfs_div #(
    .NUM_W (ROOT_USE_W),
    .DEN_W (SIZE_W),
    .Q_W   (DIST_W),
    .SB_W  (1)
  ) u_dist_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_valid),
    .num       (sq_root[ROOT_USE_W-1:0]),
    .den       (n),
    .sb_in     (sq_far),
    .out_valid (dv1_valid),
    .quot      (dv1_q),
    .sb_out    (dv1_far)
  );

  // clamp, classify, form the ramp numerator 255 * (1 - d)
  assign dist_q    = dv1_far ? D_MAX : dv1_q;
  assign one_minus = ONE_Q16 - dist_q;
  assign ramp_wide = {one_minus, 8'd0} - (RAMP_NUM_W + 1)'(one_minus);

  always_comb begin
    if (dist_q < cutoff) begin
      mode_next = MODE_FULL;
    end else if (dist_q >= ONE_Q16) begin
      mode_next = MODE_ZERO;
    end else begin
      mode_next = MODE_RAMP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_valid <= 1'b0;
    end else if (en) begin
      ramp_valid <= dv1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ramp_num  <= ramp_wide[RAMP_NUM_W-1:0];
      ramp_mode <= mode_next;
    end
  end

  // ramp quotient; only used when cutoff <= d < 1, so divisor is nonzero
  rfs_div #(
    .NUM_W (RAMP_NUM_W),
    .DEN_W (DIST_W),
    .Q_W   (GREY_W),
    .SB_W  (3)
  ) u_ramp_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (ramp_valid),
    .num       (ramp_num),
    .den       (ramp_den),
    .sb_in     (ramp_mode),
    .out_valid (dv2_valid),
    .quot      (dv2_q),
    .sb_out    (dv2_sb)
  );

  assign dv2_mode = mode_t'(dv2_sb);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      case (dv2_mode)
        MODE_FULL: grey <= GREY_FULL;
        MODE_ZERO: grey <= GREY_ZERO;
        MODE_RAMP: grey <= dv2_q;
        default:   grey <= GREY_ZERO;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> sv/rfs_offset.sv
`default_nettype none
module rfs_offset import rfs_pkg::*; #(
  parameter int CW = COORD_BITS_DEF,
  parameter int DW = ((CW + 1) > SIZE_W) ? (CW + 1) : SIZE_W,
  parameter int SW = 2 * DW + 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [CW-1:0]     row,
  input  wire logic [CW-1:0]     column,
  input  wire logic [SIZE_W-1:0] n,
  output logic                   out_valid,
  output logic [SW-1:0]          s,
  output logic                   far
);

  logic [DW-1:0]         n_ext;
  logic [DW-1:0]         tr;
  logic [DW-1:0]         tc;
  logic [DW-1:0]         dx;
  logic [DW-1:0]         dy;
  logic [2*SIZE_W-1:0]   n_sq;
  logic [2*SIZE_W+1:0]   n_sq4;
  logic                  v1;
  logic [SW-1:0]         s_sum;

  assign n_ext = DW'(n);
  assign tr    = DW'({row, 1'b1});
  assign tc    = DW'({column, 1'b1});
  assign n_sq  = {{SIZE_W{1'b0}}, n} * {{SIZE_W{1'b0}}, n};

  // stage 1: absolute half-pixel offsets
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx    <= (tr >= n_ext) ? (tr - n_ext) : (n_ext - tr);
      dy    <= (tc >= n_ext) ? (tc - n_ext) : (n_ext - tc);
      n_sq4 <= {n_sq, 2'b00};
    end
  end

  // stage 2: squared radius and far test
  assign s_sum = SW'(dx) * SW'(dx) + SW'(dy) * SW'(dy);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s   <= s_sum;
      far <= ({1'b0, s_sum} >= (SW + 1)'(n_sq4));
    end
  end

endmodule
`default_nettype wire

>>> sv/rfs_sqrt.sv
`default_nettype none
module rfs_sqrt import rfs_pkg::*; #(
  parameter int XW   = 60,
  parameter int SB_W = 1,
  parameter int RW   = XW / 2
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire logic [XW-1:0]   x_in,
  input  wire logic [SB_W-1:0] sb_in,
  output logic                 out_valid,
  output logic [RW-1:0]        root_out,
  output logic [SB_W-1:0]      sb_out
);

  logic            v    [0:RW];
  logic [RW-1:0]   root [0:RW];
  logic [RW+1:0]   rem  [0:RW];
  logic [XW-1:0]   x    [0:RW];
  logic [SB_W-1:0] sb   [0:RW];

  assign v[0]    = in_valid;
  assign root[0] = '0;
  assign rem[0]  = '0;
  assign x[0]    = x_in;
  assign sb[0]   = sb_in;

  // one result bit per stage, two radicand bits brought down each time
  for (genvar i = 0; i < RW; i++) begin : g_stage
    logic [RW+3:0] rem_sh;
    logic [RW+3:0] trial;
    logic [RW+3:0] diff;
    logic          take;

    assign rem_sh = {rem[i], x[i][XW-1 -: 2]};
    assign trial  = {2'b00, root[i], 2'b01};
    assign take   = (rem_sh >= trial);
    assign diff   = rem_sh - trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1]  <= take ? diff[RW+1:0] : rem_sh[RW+1:0];
        root[i+1] <= {root[i][RW-2:0], take};
        x[i+1]    <= x[i] << 2;
        sb[i+1]   <= sb[i];
      end
    end
  end

  assign out_valid = v[RW];
  assign root_out  = root[RW];
  assign sb_out    = sb[RW];

endmodule
`default_nettype wire

>>> sv/rfs_div.sv
`default_nettype none
module rfs_div import rfs_pkg::*; #(
  parameter int NUM_W = 30,
  parameter int DEN_W = 13,
  parameter int Q_W   = 17,
  parameter int SB_W  = 1,
  parameter int RM_W  = ((NUM_W - Q_W) > DEN_W) ? (NUM_W - Q_W) : DEN_W
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  input  wire logic [SB_W-1:0]  sb_in,
  output logic                  out_valid,
  output logic [Q_W-1:0]        quot,
  output logic [SB_W-1:0]       sb_out
);

  // restoring division, one quotient bit per stage; quotient known to fit q_w

  logic            v   [0:Q_W];
  logic [RM_W-1:0] rem [0:Q_W];
  logic [Q_W-1:0]  lo  [0:Q_W];
  logic [Q_W-1:0]  q   [0:Q_W];
  logic [SB_W-1:0] sb  [0:Q_W];

  assign v[0]   = in_valid;
  assign rem[0] = RM_W'(num[NUM_W-1:Q_W]);
  assign lo[0]  = num[Q_W-1:0];
  assign q[0]   = '0;
  assign sb[0]  = sb_in;

  for (genvar i = 0; i < Q_W; i++) begin : g_stage
    logic [RM_W:0] t;
    logic [RM_W:0] d_ext;
    logic          take;

    assign t     = {rem[i], lo[i][Q_W-1]};
    assign d_ext = (RM_W + 1)'(den);
    assign take  = (t >= d_ext);

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= take ? RM_W'(t - d_ext) : RM_W'(t);
        lo[i+1]  <= lo[i] << 1;
        q[i+1]   <= {q[i][Q_W-2:0], take};
        sb[i+1]  <= sb[i];
      end
    end
  end

  assign out_valid = v[Q_W];
  assign quot      = q[Q_W];
  assign sb_out    = sb[Q_W];

endmodule
`default_nettype wire
